/* hw/rtl/rnm_pkg.sv */
`default_nettype none

package rnm_pkg;

   localparam int MAX_PATTERN = 32;
   localparam int NPOS        = MAX_PATTERN + 1;
   localparam int POS_W       = $clog2(NPOS);
   localparam int STK_W       = $clog2(MAX_PATTERN);
   localparam int CHARS_W     = 8 * MAX_PATTERN;

   typedef logic [POS_W-1:0]   pos_type;
   typedef logic [NPOS-1:0]    row_type;
   typedef logic [7:0]         byte_type;
   typedef logic [CHARS_W-1:0] chars_type;
   typedef logic [2:0]         csr_idx_type;

   // pattern metacharacters
   localparam byte_type CH_OPEN  = 8'h28;
   localparam byte_type CH_CLOSE = 8'h29;
   localparam byte_type CH_STAR  = 8'h2A;
   localparam byte_type CH_ANY   = 8'h2E;
   localparam byte_type CH_ALT   = 8'h7C;

   // register indexes
   localparam csr_idx_type CSR_CHARS_LO     = 3'd0;
   localparam csr_idx_type CSR_CHARS_MID_LO = 3'd1;
   localparam csr_idx_type CSR_CHARS_MID_HI = 3'd2;
   localparam csr_idx_type CSR_CHARS_HI     = 3'd3;
   localparam csr_idx_type CSR_LENGTH       = 3'd4;

   // pattern byte at position k; zero at and past the end
   function automatic byte_type char_at(input chars_type chars, input pos_type n,
                                        input pos_type k);
      byte_type b;
      b = '0;
      if (k < n) begin
         b = chars[8*k[STK_W-1:0] +: 8];
      end
      return b;
   endfunction

   // build status handed from the graph builder to the stream logic
   typedef struct packed {
      logic busy;
   } build_status_type;

endpackage

`default_nettype wire

/* hw/rtl/regex_nfa_matcher_top.sv */
`default_nettype none

// Channel  Direction  Handshake           Beat
// req      in         req_valid/req_stall kind, text_char, starts_text, ends_text
// rsp      out        rsp_valid/rsp_stall accepted, is_last
// csr      in         csr_wr_en           csr_index, csr_wdata
//
// One beat per cycle while req_stall is low; each result is registered in the result
// register, or in the skid while that is held. After reset or a register write the
// graph builder initialises, walks the pattern (an extra pop for each ')' that
// closes an alternation), seeds the closure and runs one closure pivot per position,
// with req_stall held high. A two-entry output (result register plus skid) keeps
// accepting while a result waits; else req_stall rises only when both are full.
module regex_nfa_matcher_top
   import rnm_pkg::*;
(
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_valid,
   output logic             req_stall,
   input  wire logic        req_kind,
   input  wire logic [7:0]  req_text_char,
   input  wire logic        req_starts_text,
   input  wire logic        req_ends_text,
   output logic             rsp_valid,
   input  wire logic        rsp_stall,
   output logic             rsp_accepted,
   output logic             rsp_is_last,
   input  wire logic        csr_wr_en,
   input  wire csr_idx_type csr_index,
   input  wire logic [63:0] csr_wdata
);

   chars_type                 chars_ff, chars_in;
   logic [5:0]                len_ff, len_in;
   pos_type                   n;
   logic                      start;
   build_status_type          status;
   logic [NPOS-1:0][NPOS-1:0] reach;

   row_type active_ff, active_in;
   row_type cur;
   row_type next_set;
   logic    new_acc;
   logic    accept;
   logic    take;

   logic out_v_ff, out_v_in, out_acc_ff, out_acc_in, out_last_ff, out_last_in;
   logic skid_v_ff, skid_v_in, skid_acc_ff, skid_acc_in, skid_last_ff, skid_last_in;

   assign n     = (len_ff > 6'(MAX_PATTERN)) ? pos_type'(MAX_PATTERN) : pos_type'(len_ff);
   assign start = csr_wr_en && (csr_index <= CSR_LENGTH);

   // register writes
   always_comb begin
      chars_in = chars_ff;
      len_in   = len_ff;
      if (csr_wr_en) begin
         unique case (csr_index)
            CSR_CHARS_LO:     chars_in[63:0]    = csr_wdata;
            CSR_CHARS_MID_LO: chars_in[127:64]  = csr_wdata;
            CSR_CHARS_MID_HI: chars_in[191:128] = csr_wdata;
            CSR_CHARS_HI:     chars_in[255:192] = csr_wdata;
            CSR_LENGTH:       len_in            = csr_wdata[5:0];
            default: ;
         endcase
      end
   end

   rnm_graph_builder u_builder (
      .clock  (clock),
      .reset  (reset),
      .start  (start),
      .chars  (chars_in),
      .n      (pos_type'(len_in > 6'(MAX_PATTERN) ? 6'(MAX_PATTERN) : len_in)),
      .status (status),
      .reach  (reach)
   );

   assign req_stall = status.busy || skid_v_ff;
   assign accept    = req_valid && !req_stall;
   assign take      = out_v_ff && !rsp_stall;

   // one NFA step: match, advance, close
   always_comb begin
      cur      = (req_starts_text || req_kind) ? reach[0] : active_ff;
      next_set = '0;
      for (int v = 0; v < MAX_PATTERN; v++) begin
         if (cur[v] && pos_type'(v) < n &&
             (chars_ff[8*v +: 8] == req_text_char || chars_ff[8*v +: 8] == CH_ANY)) begin
            next_set = next_set | reach[v+1];
         end
      end
      if (req_kind) begin
         next_set = reach[0];
      end
      new_acc = next_set[n];
   end

   always_comb begin
      active_in = active_ff;
      if (accept) begin
         active_in = next_set;
      end
      if (start) begin
         active_in = '0;
      end
   end

   // result register and skid
   always_comb begin
      out_v_in     = out_v_ff;
      out_acc_in   = out_acc_ff;
      out_last_in  = out_last_ff;
      skid_v_in    = skid_v_ff;
      skid_acc_in  = skid_acc_ff;
      skid_last_in = skid_last_ff;
      if (take) begin
         out_v_in = skid_v_ff;
         if (skid_v_ff) begin
            out_acc_in  = skid_acc_ff;
            out_last_in = skid_last_ff;
            skid_v_in   = 1'b0;
         end
      end
      if (accept) begin
         if (!out_v_ff || take) begin
            out_v_in    = 1'b1;
            out_acc_in  = new_acc;
            out_last_in = req_ends_text;
         end else begin
            skid_v_in    = 1'b1;
            skid_acc_in  = new_acc;
            skid_last_in = req_ends_text;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         chars_ff  <= '0;
         len_ff    <= '0;
         active_ff <= '0;
         out_v_ff  <= 1'b0;
         skid_v_ff <= 1'b0;
      end else begin
         chars_ff  <= chars_in;
         len_ff    <= len_in;
         active_ff <= active_in;
         out_v_ff  <= out_v_in;
         skid_v_ff <= skid_v_in;
      end
      out_acc_ff   <= out_acc_in;
      out_last_ff  <= out_last_in;
      skid_acc_ff  <= skid_acc_in;
      skid_last_ff <= skid_last_in;
   end

   assign rsp_valid    = out_v_ff;
   assign rsp_accepted = out_acc_ff;
   assign rsp_is_last  = out_last_ff;

endmodule

`default_nettype wire

/* hw/rtl/rnm_graph_builder.sv */
`default_nettype none

module rnm_graph_builder
   import rnm_pkg::*;
(
   input  wire logic                       clock,
   input  wire logic                       reset,
   input  wire logic                       start,
   input  wire chars_type                  chars,
   input  wire pos_type                    n,
   output build_status_type                status,
   output logic [NPOS-1:0][NPOS-1:0]       reach
);

   localparam logic [2:0] ST_INIT  = 3'd0;
   localparam logic [2:0] ST_WALK  = 3'd1;
   localparam logic [2:0] ST_POP2  = 3'd2;
   localparam logic [2:0] ST_SEED  = 3'd3;
   localparam logic [2:0] ST_CLOSE = 3'd4;
   localparam logic [2:0] ST_DONE  = 3'd5;

   logic [2:0]                state_ff, state_in;
   pos_type                   pos_ff, pos_in;
   pos_type                   top_ff, top_in;
   pos_type                   alt_ff, alt_in;
   logic [STK_W-1:0]          stack_ff [MAX_PATTERN];
   logic [NPOS-1:0][NPOS-1:0] edge_ff, edge_in;
   logic [NPOS-1:0][NPOS-1:0] reach_ff, reach_in;

   byte_type         cur_char;
   pos_type          pos_p1;
   pos_type          top_m1;
   pos_type          stk_rd;
   pos_type          lp;
   logic             do_push;
   logic             do_pop;
   logic             finish;
   row_type          row_k;

   assign cur_char = char_at(chars, n, pos_ff);
   assign pos_p1   = pos_ff + pos_type'(1);
   assign top_m1   = top_ff - pos_type'(1);
   assign stk_rd   = (top_ff == '0) ? '0 : pos_type'(stack_ff[top_m1[STK_W-1:0]]);
   assign row_k    = reach_ff[pos_ff];

   always_comb begin
      state_in = state_ff;
      pos_in   = pos_ff;
      top_in   = top_ff;
      alt_in   = alt_ff;
      edge_in  = edge_ff;
      reach_in = reach_ff;
      lp       = pos_ff;
      do_push  = 1'b0;
      do_pop   = 1'b0;
      finish   = 1'b0;

      unique case (state_ff)
         ST_INIT: begin
            edge_in  = '0;
            top_in   = '0;
            pos_in   = '0;
            state_in = ST_WALK;
         end
         ST_WALK: begin
            finish = 1'b1;
            if (cur_char == CH_OPEN || cur_char == CH_ALT) begin
               do_push = 1'b1;
            end else if (cur_char == CH_CLOSE) begin
               do_pop = 1'b1;
               if (char_at(chars, n, stk_rd) == CH_ALT) begin
                  // second pop for the group start next cycle
                  alt_in   = stk_rd;
                  finish   = 1'b0;
                  state_in = ST_POP2;
               end else begin
                  lp = stk_rd;
               end
            end
         end
         ST_POP2: begin
            do_pop = 1'b1;
            lp     = stk_rd;
            finish = 1'b1;
            edge_in[stk_rd][alt_ff + pos_type'(1)] = 1'b1;
            edge_in[alt_ff][pos_ff]                = 1'b1;
         end
         ST_SEED: begin
            for (int r = 0; r < NPOS; r++) begin
               reach_in[r]    = edge_ff[r];
               reach_in[r][r] = (pos_type'(r) <= n);
            end
            pos_in   = '0;
            state_in = ST_CLOSE;
         end
         ST_CLOSE: begin
            // one closure pivot per cycle
            for (int r = 0; r < NPOS; r++) begin
               if (reach_ff[r][pos_ff]) begin
                  reach_in[r] = reach_ff[r] | row_k;
               end
            end
            if (pos_ff == n) begin
               state_in = ST_DONE;
            end else begin
               pos_in = pos_p1;
            end
         end
         default: begin
            state_in = ST_DONE;
         end
      endcase

      // stack update
      if (do_pop) begin
         top_in = (top_ff == '0) ? '0 : top_m1;
      end else if (do_push && top_ff < pos_type'(MAX_PATTERN)) begin
         top_in = top_ff + pos_type'(1);
      end

      // star loop and forward edges, then advance
      if (finish) begin
         if (pos_p1 < n && char_at(chars, n, pos_p1) == CH_STAR) begin
            edge_in[lp][pos_p1] = 1'b1;
            edge_in[pos_p1][lp] = 1'b1;
         end
         if (pos_ff < n && (cur_char == CH_OPEN || cur_char == CH_STAR ||
                            cur_char == CH_CLOSE)) begin
            edge_in[pos_ff][pos_p1] = 1'b1;
         end
         if (pos_ff == n) begin
            state_in = ST_SEED;
         end else begin
            pos_in   = pos_p1;
            state_in = ST_WALK;
         end
      end

      if (start) begin
         state_in = ST_INIT;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_INIT;
         top_ff   <= '0;
      end else begin
         state_ff <= state_in;
         top_ff   <= top_in;
      end
      pos_ff   <= pos_in;
      alt_ff   <= alt_in;
      edge_ff  <= edge_in;
      reach_ff <= reach_in;
      if (do_push && top_ff < pos_type'(MAX_PATTERN) && !start) begin
         stack_ff[top_ff[STK_W-1:0]] <= pos_ff[STK_W-1:0];
      end
   end

   assign status.busy = (state_ff != ST_DONE);
   assign reach       = reach_ff;

endmodule

`default_nettype wire

/* sim/tb_regex_nfa_matcher_top.sv */
`default_nettype none

module tb_regex_nfa_matcher_top
   import rnm_pkg::*;
();
   timeunit 1ns;
   timeprecision 1ps;

   localparam int CYCLE_LIMIT = 1000000;
   localparam int BUILD_WAIT  = 90;
   localparam int HOLD_CYCLES = 400;

   typedef struct {
      logic     kind;
      byte_type ch;
      logic     starts;
      logic     ends;
   } text_beat_type;

   typedef struct {
      logic accepted;
      logic is_last;
   } verdict_type;

   // directed row: expected verdict typed in only where has_verdict is set
   typedef struct {
      text_beat_type beat;
      logic          has_verdict;
      logic          accepted;
   } directed_row_type;

   logic        clock;
   logic        reset;
   logic        req_valid;
   logic        req_stall;
   logic        req_kind;
   logic [7:0]  req_text_char;
   logic        req_starts_text;
   logic        req_ends_text;
   logic        rsp_valid;
   logic        rsp_stall;
   logic        rsp_accepted;
   logic        rsp_is_last;
   logic        csr_wr_en;
   csr_idx_type csr_index;
   logic [63:0] csr_wdata;

   // predictor copy of the pattern and the automaton
   logic [63:0]   pat_words [4];
   logic [5:0]    pat_len;
   row_type       reach [NPOS];
   row_type       live_set;

   verdict_type   verdict_q [$];
   int            fail_count;
   int            beat_count;
   int            verdict_count;
   int            accept_count;
   int            pattern_count;
   int            cycle_count;
   bit            hold_request;

   regex_nfa_matcher_top dut (.*);

   initial begin
      clock = 1'b0;
      forever #4 clock = ~clock;
   end

   function automatic int used_len();
      return (pat_len > MAX_PATTERN) ? MAX_PATTERN : int'(pat_len);
   endfunction

   function automatic byte_type pat_char(int k);
      if (k >= used_len() || k >= 32) return 8'h00;
      return pat_words[k >> 3][(k & 7) * 8 +: 8];
   endfunction

   // rebuild epsilon graph and its closure from the current pattern
   function automatic void rebuild_automaton();
      row_type  edges [NPOS];
      int       stk [MAX_PATTERN];
      int       top;
      int       n;
      int       lp;
      int       alt;
      byte_type c;
      n = used_len();
      top = 0;
      for (int i = 0; i < NPOS; i++) edges[i] = '0;
      for (int i = 0; i <= n; i++) begin
         c = pat_char(i);
         lp = i;
         if (c == CH_OPEN || c == CH_ALT) begin
            if (top < MAX_PATTERN) begin
               stk[top] = i;
               top++;
            end
         end else if (c == CH_CLOSE) begin
            alt = 0;
            if (top > 0) begin
               top--;
               alt = stk[top];
            end
            if (pat_char(alt) == CH_ALT) begin
               lp = 0;
               if (top > 0) begin
                  top--;
                  lp = stk[top];
               end
               edges[lp][alt + 1] = 1'b1;
               edges[alt][i] = 1'b1;
            end else begin
               lp = alt;
            end
         end
         if (i + 1 < n && pat_char(i + 1) == CH_STAR) begin
            edges[lp][i + 1] = 1'b1;
            edges[i + 1][lp] = 1'b1;
         end
         if (i < n && (c == CH_OPEN || c == CH_STAR || c == CH_CLOSE))
            edges[i][i + 1] = 1'b1;
      end
      for (int i = 0; i < NPOS; i++) begin
         reach[i] = edges[i];
         reach[i][i] = 1'b1;
      end
      for (int k = 0; k <= n; k++)
         for (int i = 0; i <= n; i++)
            if (reach[i][k]) reach[i] = reach[i] | reach[k];
      for (int i = 0; i < NPOS; i++) begin
         if (i > n) reach[i] = '0;
         for (int j = n + 1; j < NPOS; j++) reach[i][j] = 1'b0;
      end
      live_set = '0;
   endfunction

   // advance the automaton by one beat and return its verdict
   function automatic verdict_type match_step(text_beat_type b);
      verdict_type v;
      row_type     nxt;
      byte_type    pc;
      int          n;
      n = used_len();
      if (b.kind) begin
         live_set = reach[0];
      end else begin
         if (b.starts) live_set = reach[0];
         nxt = '0;
         for (int p = 0; p < n; p++) begin
            pc = pat_char(p);
            if (live_set[p] && (pc == b.ch || pc == CH_ANY)) nxt = nxt | reach[p + 1];
         end
         live_set = nxt;
      end
      v.accepted = live_set[n];
      v.is_last = b.ends;
      return v;
   endfunction

   // offer one beat and hold it until accepted
   task automatic send_beat(text_beat_type b, logic has_verdict = 1'b0,
                            logic typed_accept = 1'b0);
      verdict_type v;
      req_valid <= 1'b1;
      req_kind <= b.kind;
      req_text_char <= b.ch;
      req_starts_text <= b.starts;
      req_ends_text <= b.ends;
      do @(posedge clock); while (req_stall);
      v = match_step(b);
      if (has_verdict) v.accepted = typed_accept;
      verdict_q.push_back(v);
      beat_count++;
   endtask

   task automatic idle_gap(int cycles);
      if (cycles > 0) begin
         req_valid <= 1'b0;
         repeat (cycles) @(posedge clock);
      end
   endtask

   // drain, let the builder settle, then write all registers
   task automatic load_pattern(logic [63:0] w [4], logic [5:0] len);
      req_valid <= 1'b0;
      wait (verdict_q.size() == 0);
      repeat (BUILD_WAIT) @(posedge clock);
      for (int r = 0; r < 4; r++) begin
         csr_wr_en <= 1'b1;
         csr_index <= csr_idx_type'(r);
         csr_wdata <= w[r];
         @(posedge clock);
         pat_words[r] = w[r];
      end
      csr_index <= CSR_LENGTH;
      csr_wdata <= {$urandom, $urandom} & ~64'h3F | 64'(len);
      @(posedge clock);
      pat_len = len;
      // out-of-range index must leave the pattern alone
      if ($urandom_range(0, 2) == 0) begin
         csr_index <= csr_idx_type'($urandom_range(5, 7));
         csr_wdata <= {$urandom, $urandom};
         @(posedge clock);
      end
      csr_wr_en <= 1'b0;
      rebuild_automaton();
      pattern_count++;
   endtask

   // pack a string into the pattern words, random filler past the end
   task automatic load_string(string s, int len_field);
      logic [63:0] w [4];
      for (int r = 0; r < 4; r++) w[r] = {$urandom, $urandom};
      for (int k = 0; k < s.len() && k < 32; k++) w[k >> 3][(k & 7) * 8 +: 8] = s[k];
      load_pattern(w, 6'(len_field));
   endtask

   task automatic load_random_pattern();
      string    alphabet;
      string    s;
      int       len;
      alphabet = "abc()|*.(|)*";
      len = ($urandom_range(0, 7) == 0) ? 32 : $urandom_range(1, 12);
      s = "";
      for (int k = 0; k < len; k++) begin
         if ($urandom_range(0, 15) == 0) s = {s, string'(byte'($urandom_range(1, 255)))};
         else s = {s, string'(alphabet[$urandom_range(0, alphabet.len() - 1)])};
      end
      load_string(s, len);
   endtask

   // random texts drawn mostly from the pattern's own bytes
   task automatic random_texts(int beats);
      text_beat_type b;
      int            tlen;
      int            n;
      int            burst;
      burst = $urandom_range(1, 20);
      n = used_len();
      b.kind = 1'b0;
      while (beats > 0) begin
         tlen = $urandom_range(0, 8);
         if (tlen == 0) begin
            b.kind = 1'b1;
            b.ch = byte_type'($urandom);
            b.starts = 1'($urandom_range(0, 1));
            b.ends = 1'($urandom_range(0, 1));
            tlen = 1;
         end
         for (int t = 0; t < tlen; t++) begin
            if (!b.kind || t > 0) begin
               b.kind = ($urandom_range(0, 19) == 0);
               if (n > 0 && $urandom_range(0, 9) < 7) b.ch = pat_char($urandom_range(0, n - 1));
               else b.ch = byte_type'($urandom);
               b.starts = (t == 0) ? ($urandom_range(0, 9) != 0) : ($urandom_range(0, 29) == 0);
               b.ends = (t == tlen - 1) ? 1'b1 : ($urandom_range(0, 19) == 0);
            end
            send_beat(b);
            b.kind = 1'b0;
            beats--;
            burst--;
            if (burst == 0) begin
               burst = $urandom_range(1, 20);
               idle_gap($urandom_range(0, 3) == 0 ? 0 : $urandom_range(1, 10));
            end
         end
      end
   endtask

   // receiver: shifting stall pattern, plus one long hold-off on request
   initial begin
      int phase;
      phase = 0;
      rsp_stall = 1'b0;
      forever begin
         @(posedge clock);
         if (hold_request) begin
            rsp_stall <= 1'b1;
            repeat (HOLD_CYCLES) @(posedge clock);
            hold_request = 1'b0;
            rsp_stall <= 1'b0;
         end else begin
            phase++;
            case ((phase / 150) % 3)
               0: rsp_stall <= 1'b0;
               1: rsp_stall <= ($urandom_range(0, 9) < 3);
               default: rsp_stall <= ((phase % 7) < 3);
            endcase
         end
      end
   end

   // compare each accepted result with the oldest expectation
   always @(posedge clock) begin
      verdict_type v;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (verdict_q.size() == 0) begin
            $error("result with nothing expected: accepted=%0b is_last=%0b",
                   rsp_accepted, rsp_is_last);
            fail_count++;
         end else begin
            v = verdict_q.pop_front();
            verdict_count++;
            if (v.accepted) accept_count++;
            if (rsp_accepted !== v.accepted) begin
               $error("accepted: expected %0b, got %0b", v.accepted, rsp_accepted);
               fail_count++;
            end
            if (rsp_is_last !== v.is_last) begin
               $error("is_last: expected %0b, got %0b", v.is_last, rsp_is_last);
               fail_count++;
            end
         end
      end
   end

   // watchdog
   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("timeout after %0d cycles", cycle_count);
         $display("TEST FAILED");
         $finish;
      end
   end

   initial begin
      directed_row_type rows [$];
      directed_row_type r;
      logic [63:0]      w [4];

      reset = 1'b1;
      req_valid = 1'b0;
      req_kind = 1'b0;
      req_text_char = '0;
      req_starts_text = 1'b0;
      req_ends_text = 1'b0;
      csr_wr_en = 1'b0;
      csr_index = CSR_CHARS_LO;
      csr_wdata = '0;
      fail_count = 0;
      beat_count = 0;
      verdict_count = 0;
      accept_count = 0;
      pattern_count = 0;
      cycle_count = 0;
      hold_request = 1'b0;
      for (int k = 0; k < 4; k++) pat_words[k] = '0;
      pat_len = '0;
      rebuild_automaton();
      repeat (3) @(posedge clock);
      reset <= 1'b0;

      // empty pattern after reset: empty text matches, any character fails
      rows = '{
         '{'{1'b1, 8'h00, 1'b0, 1'b1}, 1'b1, 1'b1},
         '{'{1'b0, 8'h61, 1'b1, 1'b1}, 1'b1, 1'b0},
         '{'{1'b0, 8'hFF, 1'b0, 1'b0}, 1'b1, 1'b0},
         '{'{1'b1, 8'hFF, 1'b1, 1'b0}, 1'b1, 1'b1}
      };
      foreach (rows[i]) send_beat(rows[i].beat, rows[i].has_verdict, rows[i].accepted);

      // "(a|b)*c." : alternation, star, wildcard, literal metacharacters
      load_string("(a|b)*c.", 8);
      rows = '{
         '{'{1'b0, 8'h61, 1'b0, 1'b0}, 1'b1, 1'b0},
         '{'{1'b1, 8'h00, 1'b0, 1'b1}, 1'b0, 1'b0},
         '{'{1'b0, 8'h63, 1'b1, 1'b0}, 1'b0, 1'b0},
         '{'{1'b0, 8'hFF, 1'b0, 1'b1}, 1'b0, 1'b0},
         '{'{1'b0, 8'h61, 1'b1, 1'b0}, 1'b0, 1'b0},
         '{'{1'b0, 8'h62, 1'b0, 1'b0}, 1'b0, 1'b0},
         '{'{1'b0, 8'h63, 1'b0, 1'b0}, 1'b0, 1'b0},
         '{'{1'b0, 8'h00, 1'b0, 1'b1}, 1'b0, 1'b0},
         '{'{1'b0, 8'h2A, 1'b1, 1'b0}, 1'b0, 1'b0},
         '{'{1'b0, 8'h28, 1'b1, 1'b0}, 1'b0, 1'b0},
         '{'{1'b0, 8'h63, 1'b0, 1'b0}, 1'b0, 1'b0},
         '{'{1'b0, 8'h2E, 1'b0, 1'b1}, 1'b0, 1'b0},
         '{'{1'b0, 8'h7C, 1'b0, 1'b1}, 1'b0, 1'b0}
      };
      foreach (rows[i]) send_beat(rows[i].beat, rows[i].has_verdict, rows[i].accepted);

      // oversized length saturates; unbalanced close pops an empty stack
      for (int k = 0; k < 4; k++) w[k] = {8{8'h2E}};
      load_pattern(w, 6'd63);
      r.beat = '{1'b1, 8'h00, 1'b0, 1'b0};
      send_beat(r.beat);
      for (int k = 0; k < 32; k++) send_beat('{1'b0, byte_type'($urandom), k == 0, k == 31});
      load_string(")a|b)*((", 8);
      send_beat('{1'b1, 8'h00, 1'b0, 1'b1});
      send_beat('{1'b0, 8'h61, 1'b1, 1'b1});

      // random patterns with random texts, one long receiver hold-off
      load_string("a*", 2);
      random_texts(100);
      hold_request = 1'b1;
      random_texts(150);
      load_string(".*", 2);
      random_texts(100);
      for (int p = 0; p < 10; p++) begin
         load_random_pattern();
         random_texts(125);
      end

      req_valid <= 1'b0;
      wait (verdict_q.size() == 0);
      repeat (20) @(posedge clock);
      $display("%0d beats over %0d patterns, %0d verdicts checked (%0d accepted)",
               beat_count, pattern_count, verdict_count, accept_count);
      if (fail_count == 0 && verdict_q.size() == 0) begin
         $display("TEST PASSED");
      end else begin
         $display("TEST FAILED");
      end
      $finish;
   end

endmodule

`default_nettype wire

/* sim.f */
hw/rtl/rnm_pkg.sv
hw/rtl/rnm_graph_builder.sv
hw/rtl/regex_nfa_matcher_top.sv
sim/tb_regex_nfa_matcher_top.sv
